// File: rtl/core/ltpp_pkg.sv
// ltpp_pkg: shared types and constants for the laser-target pure-pursuit block.
// No dependencies.
package ltpp_pkg;

    typedef enum logic [1:0] {
        CMD_BEAM  = 2'd0,
        CMD_SPEED = 2'd1,
        CMD_POSE  = 2'd2,
        CMD_TICK  = 2'd3
    } cmd_t;

    localparam int unsigned IN_W  = 2 + 16 + 1 + 16 + 32 + 32;
    localparam int unsigned OUT_W = 16 + 32 + 32 + 32 + 1;

    localparam logic signed [39:0] PI_Q24      = 40'sd52707179;
    localparam logic signed [39:0] TWO_PI_Q24  = 40'sd105414358;
    localparam logic signed [39:0] HALF_PI_Q24 = 40'sd26353589;
    localparam logic [23:0]        GAIN_Q24    = 24'd10188014;
    localparam logic [63:0]        MIN_L2      = 64'd2621;

    localparam logic [2:0] REG_START = 3'd0;
    localparam logic [2:0] REG_STEP  = 3'd1;
    localparam logic [2:0] REG_MIN   = 3'd2;
    localparam logic [2:0] REG_MAX   = 3'd3;
    localparam logic [2:0] REG_COUNT = 3'd4;

    // item passed from front to back
    typedef struct packed {
        cmd_t               cmd;
        logic [15:0]        beam_range;
        logic               beam_last;
        logic signed [15:0] speed_value;
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
    } item_t;

    typedef struct packed {
        logic signed [14:0] start_angle;
        logic [11:0]        angle_step;
        logic [15:0]        min_range;
        logic [15:0]        max_range;
        logic [10:0]        beam_count;
    } cfg_t;

    typedef struct packed {
        logic signed [15:0] linear_speed;
        logic signed [31:0] angular_speed;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic               target_found;
    } result_t;

    function automatic logic signed [39:0] atan_q24(input logic [4:0] i);
        logic signed [39:0] r;
        begin
            case (i)
                5'd0: r = 40'sd13176795;
                5'd1: r = 40'sd7778716;
                5'd2: r = 40'sd4110060;
                5'd3: r = 40'sd2086331;
                5'd4: r = 40'sd1047214;
                5'd5: r = 40'sd524117;
                5'd6: r = 40'sd262123;
                5'd7: r = 40'sd131069;
                default: r = 40'sd1 <<< (5'd24 - i);
            endcase
            return r;
        end
    endfunction

endpackage

// File: rtl/core/ltpp_fifo.sv
// ltpp_fifo: short item queue between front and back parts.
// Depends on ltpp_pkg.
module ltpp_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_valid,
    output logic                 wr_ready,
    input  ltpp_pkg::item_t      wr_data,
    output logic                 rd_valid,
    input  logic                 rd_ready,
    output ltpp_pkg::item_t      rd_data
);
    import ltpp_pkg::*;

    item_t      mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            if (push && !pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wr_data;
    end
endmodule

// File: rtl/core/ltpp_back.sv
// ltpp_back: executes items: beam search, CORDIC, speed, pose, yaw-rate divide.
// Depends on ltpp_pkg.
module ltpp_back #(
    parameter int MAX_BEAMS    = 1024,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ltpp_pkg::cfg_t       cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ltpp_pkg::item_t      in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ltpp_pkg::result_t    out_res
);
    import ltpp_pkg::*;

    localparam int IDX_W = $clog2(MAX_BEAMS);

    typedef enum logic [3:0] {
        S_IDLE, S_ANG, S_MOD, S_RED, S_FOLD, S_CORD, S_ROUND,
        S_L2X, S_L2Y, S_NUM, S_DIV, S_RES
    } state_t;

    state_t             state_reg;
    logic [10:0]        bcnt_reg;
    logic               hit_seen_reg;
    logic [IDX_W-1:0]   hit_idx_reg;
    logic [15:0]        hit_rng_reg;
    logic signed [31:0] tx_reg, ty_reg, px_reg, py_reg;
    logic               tvalid_reg;
    logic signed [15:0] speed_reg;
    logic signed [39:0] a_reg;
    logic signed [47:0] cx_reg, cy_reg;
    logic [4:0]         i_reg;
    logic               flip_reg;
    logic [63:0]        l2_reg, num_reg, rem_reg, q_reg;
    logic [6:0]         k_reg;
    logic               neg_reg;
    logic [31:0]        ax_reg, ay_reg;
    logic [15:0]        as_reg;
    logic               ov_reg;
    logic               ovalid_reg;
    result_t            res_reg;

    // combinational helpers
    logic [11:0]        limit;
    logic               qualifies;
    logic signed [39:0] two_pi_sh;
    logic signed [47:0] ysh, xsh;
    logic signed [47:0] rx, ry;
    logic signed [31:0] rx32, ry32;
    logic [63:0]        rem_sh, rem_sub;
    logic               bit_in;
    logic [63:0]        q_sh;

    assign in_ready  = (state_reg == S_IDLE) && !(in_item.cmd == CMD_TICK && ovalid_reg);
    assign out_valid = ovalid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        limit = (cfg.beam_count < 11'(MAX_BEAMS > 2047 ? 2047 : MAX_BEAMS))
              ? {1'b0, cfg.beam_count} : 12'(MAX_BEAMS);
        // range + 1 m below maximum: a maximum under one metre admits nothing
        qualifies = !hit_seen_reg && ({1'b0, bcnt_reg} < limit)
            && (({1'b0, in_item.beam_range} + 17'd1024) < {1'b0, cfg.max_range})
            && (in_item.beam_range > cfg.min_range);
        two_pi_sh = TWO_PI_Q24 <<< i_reg;
        ysh = cy_reg >>> i_reg;
        xsh = cx_reg >>> i_reg;
        rx  = (cx_reg + 48'sd8388608) >>> 24;
        ry  = (cy_reg + 48'sd8388608) >>> 24;
        rx32 = rx[31:0];
        ry32 = ry[31:0];
        bit_in = (k_reg >= 7'd19) ? num_reg[6'(k_reg - 7'd19)] : 1'b0;
        rem_sh = {rem_reg[62:0], bit_in};
        rem_sub = rem_sh - l2_reg;
        q_sh = {q_reg[62:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            bcnt_reg     <= '0;
            hit_seen_reg <= 1'b0;
            hit_idx_reg  <= '0;
            hit_rng_reg  <= '0;
            tx_reg <= '0; ty_reg <= '0; px_reg <= '0; py_reg <= '0;
            tvalid_reg   <= 1'b0;
            speed_reg    <= '0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            if (ovalid_reg && out_ready)
                ovalid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        case (in_item.cmd)
                            CMD_BEAM:
                            begin
                                if (qualifies)
                                begin
                                    hit_idx_reg <= bcnt_reg[IDX_W-1:0];
                                    hit_rng_reg <= in_item.beam_range;
                                end
                                if (bcnt_reg != 11'd2047)
                                    bcnt_reg <= bcnt_reg + 11'd1;
                                if (in_item.beam_last)
                                begin
                                    bcnt_reg     <= '0;
                                    hit_seen_reg <= 1'b0;
                                    if (hit_seen_reg || qualifies)
                                    begin
                                        tvalid_reg <= 1'b1;
                                        state_reg  <= S_ANG;
                                    end
                                    else
                                    begin
                                        tx_reg <= px_reg;
                                        ty_reg <= py_reg;
                                        tvalid_reg <= 1'b0;
                                    end
                                end
                                else if (qualifies)
                                    hit_seen_reg <= 1'b1;
                            end
                            CMD_SPEED: speed_reg <= tvalid_reg ? in_item.speed_value : 16'sd0;
                            CMD_POSE:
                            begin
                                px_reg <= in_item.pose_x;
                                py_reg <= in_item.pose_y;
                            end
                            default:
                            begin
                                ax_reg <= tx_reg[31] ? 32'(-tx_reg) : tx_reg;
                                ay_reg <= ty_reg[31] ? 32'(-ty_reg) : ty_reg;
                                as_reg <= speed_reg[15] ? 16'(-speed_reg) : speed_reg;
                                neg_reg <= ty_reg[31] != speed_reg[15];
                                state_reg <= S_L2X;
                            end
                        endcase
                    end
                end
                S_ANG:
                begin
                    a_reg <= ((40'(hit_idx_reg) * 40'(cfg.angle_step))
                             + {{25{cfg.start_angle[14]}}, cfg.start_angle}) <<< 12;
                    i_reg <= 5'd7;
                    state_reg <= S_MOD;
                end
                S_MOD:
                begin
                    // reduce into [0, 2*pi): add 2*pi while negative, else subtract 2*pi << k, k = 7 down to 0
                    if (a_reg < 0)
                        a_reg <= a_reg + TWO_PI_Q24;
                    else if (a_reg >= two_pi_sh)
                        a_reg <= a_reg - two_pi_sh;
                    i_reg <= i_reg - 5'd1;
                    if (i_reg == 5'd0)
                        state_reg <= S_RED;
                end
                S_RED:
                begin
                    a_reg <= (a_reg > PI_Q24) ? a_reg - TWO_PI_Q24 : a_reg;
                    state_reg <= S_FOLD;
                end
                S_FOLD:
                begin
                    flip_reg <= 1'b0;
                    if (a_reg > HALF_PI_Q24)
                    begin
                        a_reg <= a_reg - PI_Q24;
                        flip_reg <= 1'b1;
                    end
                    else if (a_reg < -HALF_PI_Q24)
                    begin
                        a_reg <= a_reg + PI_Q24;
                        flip_reg <= 1'b1;
                    end
                    cx_reg <= 48'(hit_rng_reg) * 48'(GAIN_Q24);
                    cy_reg <= '0;
                    i_reg  <= '0;
                    state_reg <= S_CORD;
                end
                S_CORD:
                begin
                    if (a_reg >= 0)
                    begin
                        cx_reg <= cx_reg - ysh;
                        cy_reg <= cy_reg + xsh;
                        a_reg  <= a_reg - atan_q24(i_reg);
                    end
                    else
                    begin
                        cx_reg <= cx_reg + ysh;
                        cy_reg <= cy_reg - xsh;
                        a_reg  <= a_reg + atan_q24(i_reg);
                    end
                    i_reg <= i_reg + 5'd1;
                    if (i_reg == 5'(CORDIC_STEPS - 1))
                        state_reg <= S_ROUND;
                end
                S_ROUND:
                begin
                    tx_reg <= flip_reg ? -rx32 : rx32;
                    ty_reg <= flip_reg ? -ry32 : ry32;
                    state_reg <= S_IDLE;
                end
                S_L2X:
                begin
                    l2_reg <= 64'(ax_reg) * 64'(ax_reg);
                    state_reg <= S_L2Y;
                end
                S_L2Y:
                begin
                    l2_reg <= l2_reg + 64'(ay_reg) * 64'(ay_reg);
                    state_reg <= S_NUM;
                end
                S_NUM:
                begin
                    num_reg <= 64'(ay_reg) * 64'(as_reg);
                    rem_reg <= '0;
                    q_reg   <= '0;
                    ov_reg  <= 1'b0;
                    k_reg   <= 7'd65;
                    if (l2_reg <= MIN_L2)
                    begin
                        speed_reg <= '0;
                        ov_reg    <= 1'b1;
                        state_reg <= S_RES;
                    end
                    else
                        state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    // restoring division, one bit per cycle; quotient saturates at 2^33
                    if (rem_sh >= l2_reg)
                    begin
                        rem_reg <= rem_sub;
                        q_reg   <= ((q_sh | 64'd1) > 64'h200000000)
                                 ? 64'h200000000 : (q_sh | 64'd1);
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        q_reg   <= (q_sh > 64'h200000000) ? 64'h200000000 : q_sh;
                    end
                    k_reg <= k_reg - 7'd1;
                    if (k_reg == 7'd0)
                        state_reg <= S_RES;
                end
                default:
                begin
                    res_reg.linear_speed <= speed_reg;
                    if (ov_reg)
                        res_reg.angular_speed <= '0;
                    else if (neg_reg)
                        res_reg.angular_speed <= (q_reg >= 64'h80000000)
                            ? 32'sh80000000 : 32'(-q_reg);
                    else
                        res_reg.angular_speed <= (q_reg > 64'h7FFFFFFF)
                            ? 32'sh7FFFFFFF : q_reg[31:0];
                    res_reg.target_x     <= tx_reg;
                    res_reg.target_y     <= ty_reg;
                    res_reg.target_found <= tvalid_reg;
                    ovalid_reg <= 1'b1;
                    state_reg  <= S_IDLE;
                end
            endcase
        end
    end
endmodule

// File: rtl/core/laser_target_pure_pursuit.sv
//  channel | dir | handshake          | payload
//  s_axis  | in  | s_tvalid/s_tready  | s_tuser=cmd, s_tlast=beam_last, s_tdata
//  m_axis  | out | m_tvalid/m_tready  | m_tdata results
//  apb     | in  | psel/penable       | five config registers at 4*i
// Beam, speed and pose items are handled in the back part's idle state; a last beam
// with a hit runs the angle states (8-step angle reduction) and the CORDIC steps, a tick
// runs the 66-step restoring divider, which it skips when L is at most 0.05 m.
// A two-entry queue parts the input from the back part; the result register holds a
// tick's result while other items keep flowing. rst_n resets control state and config.
module laser_target_pure_pursuit #(
    parameter int MAX_BEAMS    = 1024,
    parameter int CORDIC_STEPS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,  // beam_range[15:0], speed_value[31:16], pose_x, pose_y
    input  logic [1:0]   s_tuser,  // cmd
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [119:0] m_tdata,  // linear_speed, angular_speed, target_x, target_y, found
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import ltpp_pkg::*;

    cfg_t    cfg_reg;
    item_t   in_item, q_item;
    logic    q_valid, q_ready;
    result_t res;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_angle <= -15'sd12868;
            cfg_reg.angle_step  <= 12'd26;
            cfg_reg.min_range   <= 16'd100;
            cfg_reg.max_range   <= 16'd30720;
            cfg_reg.beam_count  <= 11'd512;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[4:2])
                REG_START: cfg_reg.start_angle <= pwdata[14:0];
                REG_STEP:  cfg_reg.angle_step  <= pwdata[11:0];
                REG_MIN:   cfg_reg.min_range   <= pwdata[15:0];
                REG_MAX:   cfg_reg.max_range   <= pwdata[15:0];
                REG_COUNT: cfg_reg.beam_count  <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_START: prdata = {{17{cfg_reg.start_angle[14]}}, cfg_reg.start_angle};
            REG_STEP:  prdata = {20'd0, cfg_reg.angle_step};
            REG_MIN:   prdata = {16'd0, cfg_reg.min_range};
            REG_MAX:   prdata = {16'd0, cfg_reg.max_range};
            REG_COUNT: prdata = {21'd0, cfg_reg.beam_count};
            default:   prdata = '0;
        endcase
    end

    always_comb
    begin
        in_item.cmd         = cmd_t'(s_tuser);
        in_item.beam_range  = s_tdata[15:0];
        in_item.beam_last   = s_tlast;
        in_item.speed_value = s_tdata[31:16];
        in_item.pose_x      = s_tdata[63:32];
        in_item.pose_y      = s_tdata[95:64];
    end

    ltpp_fifo u_fifo (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(s_tvalid), .wr_ready(s_tready), .wr_data(in_item),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_item)
    );

    ltpp_back #(.MAX_BEAMS(MAX_BEAMS), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg),
        .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
    );

    assign m_tdata = {7'd0, res.target_found, res.target_y, res.target_x,
                      res.angular_speed, res.linear_speed};
endmodule

// File: tb/laser_target_pure_pursuit_tb.sv
// Self-checking testbench for laser_target_pure_pursuit: stream items in,
// control-tick results checked against an in-bench steering predictor.
// Depends on ltpp_pkg and the block's RTL.
module laser_target_pure_pursuit_tb;
    import ltpp_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [95:0]  s_tdata;  // beam_range, speed_value, pose_x, pose_y
    logic [1:0]   s_tuser;  // cmd
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [119:0] m_tdata;  // linear_speed, angular_speed, target_x, target_y, found
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    laser_target_pure_pursuit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 100;

    item_t   pending_items[$];
    result_t steer_expected[$];
    int      n_fail;
    int      idle_cycles;
    int      burst_left;
    int      gap_left;
    int      stall_mode;
    int      stall_timer;

    // predictor copy of registers and state
    cfg_t               cfg;
    logic [10:0]        scan_pos;
    bit                 hit_seen_q;
    logic [9:0]         hit_idx;
    logic [15:0]        hit_rng;
    logic signed [31:0] tgt_x;
    logic signed [31:0] tgt_y;
    bit                 tgt_ok;
    logic signed [15:0] spd;
    logic signed [31:0] odo_x;
    logic signed [31:0] odo_y;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint arctan_q24(int i);
        longint tab[8];
        tab = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069};
        if (i < 8)
            return tab[i];
        return longint'(1) << (24 - i);
    endfunction

    task automatic beam_to_target();
        longint a;
        longint x;
        longint y;
        longint nx;
        bit     flip;
        flip = 1'b0;
        a = (longint'(hit_idx) * longint'(cfg.angle_step) + longint'(cfg.start_angle)) * 4096;
        a = a % 64'sd105414358;
        if (a < 0)
            a = a + 64'sd105414358;
        if (a > 64'sd52707179)
            a = a - 64'sd105414358;
        if (a > 64'sd26353589)
        begin
            a = a - 64'sd52707179;
            flip = 1'b1;
        end
        else if (a < -64'sd26353589)
        begin
            a = a + 64'sd52707179;
            flip = 1'b1;
        end
        x = longint'(hit_rng) * 64'sd10188014;
        y = 0;
        for (int i = 0; i < 16; i++)
        begin
            if (a >= 0)
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                a = a - arctan_q24(i);
            end
            else
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                a = a + arctan_q24(i);
            end
            x = nx;
        end
        x = (x + (longint'(1) << 23)) >>> 24;
        y = (y + (longint'(1) << 23)) >>> 24;
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        tgt_x = x[31:0];
        tgt_y = y[31:0];
    endtask

    // yaw rate = speed * 2y / L^2 in Q15.16, restoring division with saturation
    task automatic compute_yaw(output logic signed [31:0] yaw);
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned as;
        longint unsigned l2;
        longint unsigned num;
        longint unsigned rem;
        longint unsigned q;
        longint unsigned b;
        bit              neg;
        ax = (tgt_x < 0) ? -longint'(tgt_x) : longint'(tgt_x);
        ay = (tgt_y < 0) ? -longint'(tgt_y) : longint'(tgt_y);
        as = (spd < 0) ? -longint'(spd) : longint'(spd);
        l2 = ax * ax + ay * ay;
        num = ay * as;
        neg = (tgt_y < 0) != (spd < 0);
        rem = 0;
        q = 0;
        if (l2 <= 64'd2621)
        begin
            spd = '0;
            yaw = '0;
            return;
        end
        for (int k = 65; k >= 0; k--)
        begin
            b = (k >= 19) ? ((num >> (k - 19)) & 64'd1) : 64'd0;
            rem = (rem << 1) | b;
            q = q << 1;
            if (rem >= l2)
            begin
                rem = rem - l2;
                q = q | 64'd1;
            end
            if (q > (64'd1 << 33))
                q = 64'd1 << 33;
        end
        if (neg)
            yaw = (q >= (64'd1 << 31)) ? 32'sh80000000 : -q[31:0];
        else
            yaw = (q > 64'h7FFFFFFF) ? 32'sh7FFFFFFF : q[31:0];
    endtask

    task automatic predict_steering(input item_t it);
        int      limit;
        result_t r;
        case (it.cmd)
            CMD_BEAM:
            begin
                limit = (cfg.beam_count < 1024) ? int'(cfg.beam_count) : 1024;
                if (!hit_seen_q && int'(scan_pos) < limit
                    && int'(it.beam_range) < int'(cfg.max_range) - 1024
                    && it.beam_range > cfg.min_range)
                begin
                    hit_seen_q = 1'b1;
                    hit_idx = scan_pos[9:0];
                    hit_rng = it.beam_range;
                end
                if (scan_pos < 11'd2047)
                    scan_pos = scan_pos + 11'd1;
                if (it.beam_last)
                begin
                    if (hit_seen_q)
                    begin
                        beam_to_target();
                        tgt_ok = 1'b1;
                    end
                    else
                    begin
                        tgt_x = odo_x;
                        tgt_y = odo_y;
                        tgt_ok = 1'b0;
                    end
                    scan_pos = '0;
                    hit_seen_q = 1'b0;
                end
            end
            CMD_SPEED: spd = tgt_ok ? it.speed_value : 16'sd0;
            CMD_POSE:
            begin
                odo_x = it.pose_x;
                odo_y = it.pose_y;
            end
            default:
            begin
                compute_yaw(r.angular_speed);
                r.linear_speed = spd;
                r.target_x = tgt_x;
                r.target_y = tgt_y;
                r.target_found = tgt_ok;
                steer_expected.push_back(r);
            end
        endcase
    endtask

    // driver: bursts of items with random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || s_tready)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                item_t it;
                it = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= it.cmd;
                s_tlast  <= it.beam_last;
                s_tdata  <= {it.pose_y, it.pose_x, it.speed_value, it.beam_range};
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver back-pressure in random modes, re-chosen when stall_timer runs out
    always @(posedge clk)
    begin
        if (stall_timer == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            stall_timer <= $urandom_range(50, 400);
        end
        else
            stall_timer <= stall_timer - 1;
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= $urandom_range(0, 1);
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // monitor: predict on input acceptance, check on result acceptance
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                item_t it;
                it.cmd = cmd_t'(s_tuser);
                it.beam_last = s_tlast;
                it.beam_range = s_tdata[15:0];
                it.speed_value = s_tdata[31:16];
                it.pose_x = s_tdata[63:32];
                it.pose_y = s_tdata[95:64];
                predict_steering(it);
            end
            if (m_tvalid && m_tready)
            begin
                if (steer_expected.size() == 0)
                begin
                    $error("unexpected result item");
                    n_fail++;
                end
                else
                begin
                    result_t e;
                    e = steer_expected.pop_front();
                    if (m_tdata[15:0] !== e.linear_speed)
                    begin
                        $error("linear_speed exp %0d got %0d", e.linear_speed,
                            $signed(m_tdata[15:0]));
                        n_fail++;
                    end
                    if (m_tdata[47:16] !== e.angular_speed)
                    begin
                        $error("angular_speed exp %0d got %0d", e.angular_speed,
                            $signed(m_tdata[47:16]));
                        n_fail++;
                    end
                    if (m_tdata[79:48] !== e.target_x)
                    begin
                        $error("target_x exp %0d got %0d", e.target_x,
                            $signed(m_tdata[79:48]));
                        n_fail++;
                    end
                    if (m_tdata[111:80] !== e.target_y)
                    begin
                        $error("target_y exp %0d got %0d", e.target_y,
                            $signed(m_tdata[111:80]));
                        n_fail++;
                    end
                    if (m_tdata[112] !== e.target_found)
                    begin
                        $error("target_found exp %0d got %0d", e.target_found, m_tdata[112]);
                        n_fail++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAILED: results differ");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic item_t random_item(cmd_t c);
        item_t        it;
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        it = raw[IN_W-1:0];
        it.cmd = c;
        return it;
    endfunction

    task automatic push_beam(logic [15:0] r, bit last);
        item_t it;
        it = random_item(CMD_BEAM);
        it.beam_range = r;
        it.beam_last = last;
        pending_items.push_back(it);
    endtask

    task automatic push_speed(logic signed [15:0] v);
        item_t it;
        it = random_item(CMD_SPEED);
        it.speed_value = v;
        pending_items.push_back(it);
    endtask

    task automatic push_pose(logic signed [31:0] x, logic signed [31:0] y);
        item_t it;
        it = random_item(CMD_POSE);
        it.pose_x = x;
        it.pose_y = y;
        pending_items.push_back(it);
    endtask

    task automatic push_tick();
        pending_items.push_back(random_item(CMD_TICK));
    endtask

    task automatic apb_write(logic [2:0] idx, logic [31:0] v);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= $urandom_range(0, 1);
        case (idx)
            REG_START: cfg.start_angle = v[14:0];
            REG_STEP:  cfg.angle_step = v[11:0];
            REG_MIN:   cfg.min_range = v[15:0];
            REG_MAX:   cfg.max_range = v[15:0];
            default:   cfg.beam_count = v[10:0];
        endcase
    endtask

    // upper bits are junk at times; the register keeps only its own width
    task automatic write_config(int sa, int st, int mn, int mx, int bc);
        logic [31:0] junk;
        junk = ($urandom_range(0, 1) == 0) ? 32'd0 : $urandom;
        apb_write(REG_START, {junk[31:15], 15'(sa)});
        apb_write(REG_STEP, {junk[31:12], 12'(st)});
        apb_write(REG_MIN, {junk[31:16], 16'(mn)});
        apb_write(REG_MAX, {junk[31:16], 16'(mx)});
        apb_write(REG_COUNT, {junk[31:11], 11'(bc)});
    endtask

    task automatic wait_drained();
        while (pending_items.size() > 0 || s_tvalid || steer_expected.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // in-window ranges a quarter of the time, so hits land at varied positions
    task automatic random_scan(int len);
        int lo;
        int hi;
        int r;
        lo = int'(cfg.min_range) + 1;
        hi = int'(cfg.max_range) - 1025;
        for (int i = 0; i < len; i++)
        begin
            if (lo <= hi && $urandom_range(0, 3) == 0)
                r = $urandom_range(lo, hi);
            else if ($urandom_range(0, 2) == 0)
                r = $urandom_range(0, 65535);
            else if ($urandom_range(0, 1) == 0)
                r = $urandom_range(0, int'(cfg.min_range));
            else
                r = $urandom_range((hi > 0 ? hi + 1 : 0), 65535);
            push_beam(16'(r), i == len - 1);
        end
    endtask

    task automatic random_phase(int n_items);
        int start_n;
        start_n = pending_items.size();
        while (pending_items.size() - start_n < n_items)
        begin
            if ($urandom_range(0, 4) != 0)
            begin
                if ($urandom_range(0, 3) == 0)
                    push_pose($urandom, $urandom);
                random_scan($urandom_range(1, 24));
                if ($urandom_range(0, 4) != 0)
                    push_speed(16'($urandom));
                push_tick();
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0: push_beam(16'($urandom), 1'($urandom_range(0, 1)));
                    1: push_speed(16'($urandom));
                    2: push_pose($urandom, $urandom);
                    default: push_tick();
                endcase
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        n_fail = 0;
        idle_cycles = 0;
        burst_left = 1;
        gap_left = 0;
        stall_mode = 0;
        stall_timer = 0;
        cfg.start_angle = -15'sd12868;
        cfg.angle_step = 12'd26;
        cfg.min_range = 16'd100;
        cfg.max_range = 16'd30720;
        cfg.beam_count = 11'd512;
        scan_pos = '0;
        hit_seen_q = 1'b0;
        hit_idx = '0;
        hit_rng = '0;
        tgt_x = '0;
        tgt_y = '0;
        tgt_ok = 1'b0;
        spd = '0;
        odo_x = '0;
        odo_y = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset configuration
        push_tick();
        push_speed(16'sd1000);                  // no target yet: stored as zero
        push_pose(32'sh80000000, 32'sh7FFFFFFF);
        push_beam(16'd100, 1'b1);               // range equal to minimum: no hit
        push_tick();
        push_pose(32'sd1, -32'sd1);
        push_beam(16'd0, 1'b1);
        push_speed(16'sd500);
        push_tick();                            // L tiny: speed forced to zero
        push_beam(16'd29696, 1'b0);             // at max less one metre: rejected
        push_beam(16'd5000, 1'b0);
        push_beam(16'd65535, 1'b1);
        push_speed(16'sh7FFF);
        push_tick();
        push_speed(16'sh8000);
        push_tick();
        push_beam(16'd20000, 1'b1);             // single-beam scan, last beam hits
        push_tick();
        push_pose(32'sh80000000, 32'sh80000000);
        push_beam(16'd101, 1'b1);
        push_speed(-16'sd1);
        push_tick();
        random_phase(50);
        wait_drained();

        write_config(-16384, 4095, 0, 65535, 1024);
        random_phase(30);
        wait_drained();
        write_config(16383, 0, 65535, 0, 1);
        random_phase(20);
        wait_drained();
        write_config(0, 1, 0, 1023, 16);        // maximum below one metre
        random_phase(20);
        wait_drained();

        // long scan: hit on the final searched beam, later in-window beam ignored
        write_config($urandom_range(0, 32767), $urandom_range(0, 4095), 0, 65535, 600);
        for (int i = 0; i < 900; i++)
            push_beam((i == 599 || i == 700) ? 16'($urandom_range(1, 64510)) : 16'd0,
                i == 899);
        push_speed(16'($urandom));
        push_tick();
        wait_drained();

        for (int ph = 0; ph < 8; ph++)
        begin
            int mn;
            mn = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 4000);
            write_config($urandom_range(0, 32767), $urandom_range(0, 4095), mn,
                $urandom_range(0, 65535), ($urandom_range(0, 1) == 0) ?
                $urandom_range(1, 12) : $urandom_range(1, 1024));
            random_phase(15);
            wait_drained();
        end

        if (n_fail == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
